@@ rtl/csrmv_pkg.sv @@
// Shared types and constants for the CSR sparse matrix-vector multiplier.
// No dependencies; imported by every module of the block except csrmv_ram.
package csrmv_pkg;

    // Storage and index sizes
    localparam int VEC_DEPTH = 4096;
    localparam int MAX_ROWS  = 65536;
    localparam int VEC_AW    = $clog2(VEC_DEPTH);
    localparam int IDX_W     = 12;
    localparam int ROW_W     = 16;
    localparam int NROWS_W   = 17;
    localparam int VLEN_W    = 13;
    localparam int VAL_W     = 32;
    localparam int SUM_W     = 64;

    // Configuration register map
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;
    localparam logic REG_NUM_ROWS   = 1'b0;
    localparam logic REG_VEC_LENGTH = 1'b1;
    localparam logic [NROWS_W-1:0] NUM_ROWS_RST   = NROWS_W'(1);
    localparam logic [VLEN_W-1:0]  VEC_LENGTH_RST = VLEN_W'(4096);

    // Request opcodes, same encoding as the func field
    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_NONZERO = 2'd1,
        OP_EMPTY   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // Saturation bounds of the Q32.32 accumulator
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // One request as handed from the front end to the multiply-accumulate path
    typedef struct packed {
        logic                    vld;
        op_t                     op;
        logic                    err;
        logic                    last;
        logic signed [VAL_W-1:0] value;
    } item_t;

    // Saturating signed add
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W-1:0] s;
        s = a + b;
        if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
            s = a[SUM_W-1] ? SUM_MIN : SUM_MAX;
        end
        return s;
    endfunction

endpackage

@@ rtl/csr_sparse_matvec.sv @@
// Top level of the CSR sparse matrix-vector multiplier.
// Depends on csrmv_pkg, csrmv_ram, csrmv_cfg and csrmv_mac.
//
// Load the dense vector with func 0 requests, then stream the matrix nonzeros
// in row order (func 1, tlast on the last nonzero of a row; func 2 for an empty
// row); func travels on s_tuser. The block takes one request per clock cycle
// unless a stalled result holds a row-closing request and stage 1 is full.
// A row sum passes the 4096 x 32 vector store RAM, read as the request that
// closes the row is accepted, then the registered 32 x 32 multiply, then the
// saturating 64-bit accumulate that loads the output register.
// A stalled result holds only a row-closing request in the accumulate stage;
// other requests keep flowing and earlier stages fill behind it.
// No clearing pass is needed after reset: reading a never written vector
// element returns undefined data.
module csr_sparse_matvec
    import csrmv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Request channel
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // index[11:0], value[43:12], zero pad
    input  logic [1:0]        s_tuser,   // func[1:0]
    input  logic              s_tlast,   // row_end
    // Result channel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [79:0]       m_tdata,   // row_index[15:0], row_sum[79:16]
    output logic              m_tuser,   // column_error
    output logic              m_tlast,   // matrix_done
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    logic [NROWS_W-1:0]      num_rows;
    logic [VLEN_W-1:0]       vec_length;
    op_t                     in_op;
    logic [IDX_W-1:0]        in_index;
    logic signed [VAL_W-1:0] in_value;
    logic                    in_range;
    logic                    take;
    logic                    accept;
    item_t                   item;
    logic [VAL_W-1:0]        vec_data;
    logic [ROW_W-1:0]        row_index;
    logic signed [SUM_W-1:0] row_sum;

    // Request decode
    assign in_op    = op_t'(s_tuser);
    assign in_index = s_tdata[11:0];
    assign in_value = s_tdata[43:12];
    assign in_range = (32'(in_index) < 32'(VEC_DEPTH));
    assign accept   = s_tvalid && take;
    assign s_tready = take;

    always_comb begin
        item.vld   = s_tvalid && (in_op != OP_NONE);
        item.op    = in_op;
        item.err   = !in_range || ({1'b0, in_index} >= vec_length);
        item.last  = s_tlast;
        item.value = in_value;
    end

    csrmv_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .num_rows   (num_rows),
        .vec_length (vec_length)
    );

    // Vector store: written by func 0, read by func 1
    csrmv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (VEC_DEPTH)
    ) u_vec_ram (
        .aclk  (aclk),
        .we    (accept && (in_op == OP_WRITE) && in_range),
        .waddr (VEC_AW'(in_index)),
        .wdata (in_value),
        .re    (take),
        .raddr (VEC_AW'(in_index)),
        .rdata (vec_data)
    );

    csrmv_mac u_mac (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .item             (item),
        .take             (take),
        .vec_data         (vec_data),
        .num_rows         (num_rows),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_row_index    (row_index),
        .out_row_sum      (row_sum),
        .out_column_error (m_tuser),
        .out_matrix_done  (m_tlast)
    );

    assign m_tdata = {row_sum, row_index};

endmodule

@@ rtl/csrmv_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module csrmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/csrmv_cfg.sv @@
// APB-style register file holding num_rows and vec_length.
// Depends on csrmv_pkg.
module csrmv_cfg
    import csrmv_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CFG_AW-1:0]   paddr,
    input  logic [CFG_DW-1:0]   pwdata,
    output logic [CFG_DW-1:0]   prdata,
    output logic                pready,
    output logic [NROWS_W-1:0]  num_rows,
    output logic [VLEN_W-1:0]   vec_length
);

    logic [NROWS_W-1:0] num_rows_reg;
    logic [VLEN_W-1:0]  vec_length_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes, decoded on the word address bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg   <= NUM_ROWS_RST;
            vec_length_reg <= VEC_LENGTH_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_NUM_ROWS:   num_rows_reg   <= pwdata[NROWS_W-1:0];
                REG_VEC_LENGTH: vec_length_reg <= pwdata[VLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (paddr[2])
            REG_NUM_ROWS:   prdata = CFG_DW'(num_rows_reg);
            REG_VEC_LENGTH: prdata = CFG_DW'(vec_length_reg);
            default:        prdata = '0;
        endcase
    end

    assign num_rows   = num_rows_reg;
    assign vec_length = vec_length_reg;

endmodule

@@ rtl/csrmv_mac.sv @@
// Multiply and saturating accumulate pipeline with row emission and output register.
// Depends on csrmv_pkg; takes vector data from the store RAM, read as a request enters stage 1.
module csrmv_mac
    import csrmv_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  item_t                   item,
    output logic                    take,
    input  logic signed [VAL_W-1:0] vec_data,
    input  logic [NROWS_W-1:0]      num_rows,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ROW_W-1:0]        out_row_index,
    output logic signed [SUM_W-1:0] out_row_sum,
    output logic                    out_column_error,
    output logic                    out_matrix_done
);

    // Multiply stage (vector data arrives from RAM here)
    logic                    s1_vld_reg;
    op_t                     s1_op_reg;
    logic                    s1_err_reg;
    logic                    s1_last_reg;
    logic signed [VAL_W-1:0] s1_val_reg;

    // Accumulate stage
    logic                    s2_vld_reg;
    op_t                     s2_op_reg;
    logic                    s2_err_reg;
    logic                    s2_last_reg;
    logic signed [SUM_W-1:0] s2_prod_reg;

    // Row state
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic [ROW_W-1:0]        cnt_reg, cnt_next;
    logic                    rerr_reg, rerr_next;

    // Output register
    logic                    m_vld_reg;
    logic [ROW_W-1:0]        m_row_reg;
    logic signed [SUM_W-1:0] m_sum_reg;
    logic                    m_err_reg;
    logic                    m_done_reg;

    logic                    out_free;
    logic                    s2_emit;
    logic                    adv2;
    logic signed [SUM_W-1:0] mul;
    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W-1:0] sum;
    logic                    err_row;
    logic                    done;
    logic                    emit;

    assign out_free = !m_vld_reg || out_ready;
    assign s2_emit  = (s2_op_reg == OP_EMPTY) || ((s2_op_reg == OP_NONZERO) && s2_last_reg);
    assign adv2     = !s2_vld_reg || !s2_emit || out_free;
    assign take     = !s1_vld_reg || adv2;

    // Stage 1 capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (take) begin
            s1_vld_reg <= item.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            s1_op_reg   <= item.op;
            s1_err_reg  <= item.err;
            s1_last_reg <= item.last;
            s1_val_reg  <= item.value;
        end
    end

    // Q16.16 x Q16.16 gives exact Q32.32; a bad column contributes zero
    assign mul  = s1_val_reg * vec_data;
    assign prod = (s1_op_reg == OP_NONZERO && !s1_err_reg) ? mul : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (adv2) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            s2_op_reg   <= s1_op_reg;
            s2_err_reg  <= s1_err_reg;
            s2_last_reg <= s1_last_reg;
            s2_prod_reg <= prod;
        end
    end

    // Accumulate and row bookkeeping
    assign sum     = (s2_op_reg == OP_NONZERO) ? sat_add(acc_reg, s2_prod_reg) : acc_reg;
    assign err_row = rerr_reg || ((s2_op_reg == OP_NONZERO) && s2_err_reg);
    assign done    = (num_rows != '0) && ({1'b0, cnt_reg} == num_rows - NROWS_W'(1));
    assign emit    = s2_vld_reg && adv2 && s2_emit;

    always_comb begin
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        rerr_next = rerr_reg;
        if (s2_vld_reg && adv2) begin
            case (s2_op_reg)
                OP_WRITE: begin
                    acc_next  = '0;
                    cnt_next  = '0;
                    rerr_next = 1'b0;
                end
                OP_NONZERO, OP_EMPTY: begin
                    acc_next  = sum;
                    rerr_next = err_row;
                end
                default: ;
            endcase
            if (s2_emit) begin
                acc_next  = '0;
                rerr_next = 1'b0;
                if (done || ({1'b0, cnt_reg} == NROWS_W'(MAX_ROWS - 1))) begin
                    cnt_next = '0;
                end else begin
                    cnt_next = cnt_reg + ROW_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            cnt_reg  <= '0;
            rerr_reg <= 1'b0;
        end else begin
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            rerr_reg <= rerr_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (emit) begin
            m_vld_reg <= 1'b1;
        end else if (out_ready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_row_reg  <= cnt_reg;
            m_sum_reg  <= sum;
            m_err_reg  <= err_row;
            m_done_reg <= done;
        end
    end

    assign out_valid        = m_vld_reg;
    assign out_row_index    = m_row_reg;
    assign out_row_sum      = m_sum_reg;
    assign out_column_error = m_err_reg;
    assign out_matrix_done  = m_done_reg;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for csr_sparse_matvec: APB register writes, stream requests,
// and a row-sum predictor that checks every result.
// Depends on csrmv_pkg and the csr_sparse_matvec RTL.
module tb;
    import csrmv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 4000;  // cycles with no transfer before giving up
    localparam int DRAIN_CYCLES = 8;     // pipeline is three deep; allow some slack

    // One expected row result
    typedef struct {
        logic [ROW_W-1:0]        row;
        logic signed [SUM_W-1:0] sum;
        logic                    err;
        logic                    done;
    } row_sum_t;

    // Predicts row sums from accepted requests and checks them in order
    class row_sum_board;
        logic signed [VAL_W-1:0] vec_mem [VEC_DEPTH];
        logic signed [SUM_W-1:0] acc;
        logic [ROW_W-1:0]        row_cnt;
        logic                    row_err;
        logic [NROWS_W-1:0]      num_rows;
        logic [VLEN_W-1:0]       vec_len;
        row_sum_t                rows_due[$];
        int mismatches, rows_checked, err_rows, done_rows, sat_rows;

        function new();
            foreach (vec_mem[i]) vec_mem[i] = '0;
            acc          = '0;
            row_cnt      = '0;
            row_err      = 1'b0;
            num_rows     = NUM_ROWS_RST;
            vec_len      = VEC_LENGTH_RST;
            mismatches   = 0;
            rows_checked = 0;
            err_rows     = 0;
            done_rows    = 0;
            sat_rows     = 0;
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

        function void set_register(logic regsel, logic [CFG_DW-1:0] v);
            if (regsel == REG_NUM_ROWS) begin
                num_rows = v[NROWS_W-1:0];
            end else begin
                vec_len = v[VLEN_W-1:0];
            end
        endfunction

        // Clamp to the Q32.32 bounds after every term
        function logic signed [SUM_W-1:0] clamp_add(logic signed [SUM_W-1:0] a,
                                                    logic signed [SUM_W-1:0] b);
            logic signed [SUM_W:0] wide;
            wide = a;
            wide = wide + b;
            if (wide[SUM_W] != wide[SUM_W-1]) begin
                return wide[SUM_W] ? SUM_MIN : SUM_MAX;
            end
            return wide[SUM_W-1:0];
        endfunction

        function void close_row();
            row_sum_t r;
            r.row  = row_cnt;
            r.sum  = acc;
            r.err  = row_err;
            r.done = (num_rows != '0) && ({1'b0, row_cnt} == num_rows - 1'b1);
            rows_due.push_back(r);
            row_cnt = r.done ? '0 : row_cnt + 1'b1;
            acc     = '0;
            row_err = 1'b0;
        endfunction

        function void note_request(op_t f, logic [IDX_W-1:0] idx,
                                   logic signed [VAL_W-1:0] v, logic last);
            logic signed [SUM_W-1:0] prod;
            case (f)
                OP_WRITE: begin
                    vec_mem[idx] = v;
                    row_cnt      = '0;
                    acc          = '0;
                    row_err      = 1'b0;
                end
                OP_NONZERO: begin
                    if (int'(idx) >= int'(vec_len)) begin
                        row_err = 1'b1;
                    end else begin
                        prod = v * vec_mem[idx];
                        acc  = clamp_add(acc, prod);
                    end
                    if (last) close_row();
                end
                OP_EMPTY: close_row();
                default: ;
            endcase
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] FAIL: %s", $time, msg);
        endtask

        task check_result(logic [ROW_W-1:0] row, logic signed [SUM_W-1:0] sum,
                          logic err, logic done);
            row_sum_t r;
            if (rows_due.size() == 0) begin
                report($sformatf("row %0d result arrived with nothing outstanding", row));
                return;
            end
            r = rows_due.pop_front();
            rows_checked++;
            if (r.err) err_rows++;
            if (r.done) done_rows++;
            if (r.sum == SUM_MAX || r.sum == SUM_MIN) sat_rows++;
            if (row !== r.row)
                report($sformatf("row_index %0d, wanted %0d", row, r.row));
            if (sum !== r.sum)
                report($sformatf("row %0d row_sum %h, wanted %h", r.row, sum, r.sum));
            if (err !== r.err)
                report($sformatf("row %0d column_error %b, wanted %b", r.row, err, r.err));
            if (done !== r.done)
                report($sformatf("row %0d matrix_done %b, wanted %b", r.row, done, r.done));
        endtask
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata = '0;   // index[11:0], value[43:12], zero pad
    logic [1:0]        s_tuser = '0;   // func[1:0]
    logic              s_tlast = 1'b0; // row_end
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [79:0]       m_tdata;        // row_index[15:0], row_sum[79:16]
    logic              m_tuser;        // column_error
    logic              m_tlast;        // matrix_done
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [CFG_DW-1:0] pwdata = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    row_sum_board sb = new();

    bit   loaded [VEC_DEPTH];   // vector entries written at least once
    int   loaded_list[$];
    int   burst_left = 0;
    int   sent_items = 0;
    int   rx_cyc = 0;
    int   quiet = 0;
    int   settings_done = 0;

    csr_sparse_matvec dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Result side stalls: its pattern rotates among four modes as rx_cyc advances
    always @(negedge aclk) begin
        rx_cyc <= rx_cyc + 1;
        case ((rx_cyc / 250) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 7);
            2: m_tready <= ((rx_cyc % 16) < 5);
            default: m_tready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[15:0], m_tdata[79:16], m_tuser, m_tlast);
    end

    // Watchdog on cycles where nothing moves
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Watchdog: nothing transferred for %0d cycles", QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Stop sending and wait until every row sum is back and the pipe is empty
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // One request; the sender idles between bursts of random length
    task automatic send_req(op_t f, int idx, logic [VAL_W-1:0] v, logic last);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 48);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'b0000, v, idx[IDX_W-1:0]};
        s_tuser  = f;
        s_tlast  = last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(f, idx[IDX_W-1:0], v, last);
        if (f == OP_WRITE && !loaded[idx]) begin
            loaded[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
        if (f != OP_NONE) sent_items++;
        burst_left--;
        @(negedge aclk);
    endtask

    // Register write followed by a readback, only with the block idle
    task automatic cfg_write(logic regsel, logic [CFG_DW-1:0] v);
        logic [CFG_DW-1:0] rd, mask;
        drain();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CFG_AW'({regsel, 2'b00});
        pwdata  = v;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_register(regsel, v);
        @(negedge aclk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rd = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        mask = (regsel == REG_NUM_ROWS) ? CFG_DW'((1 << NROWS_W) - 1)
                                        : CFG_DW'((1 << VLEN_W) - 1);
        if ((rd & mask) !== (v & mask))
            sb.report($sformatf("register at %0d reads %h, wrote %h", paddr, rd, v));
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = '0;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3: begin
                // a few units in Q16.16
                v = $urandom_range(0, 32'h0008_0000);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Column for a nonzero: mostly in range, sometimes past vec_length.
    // Only entries already written are ever addressed.
    function automatic int pick_column();
        int  lim, c;
        bit  bad;
        lim = (sb.vec_len > VEC_DEPTH) ? VEC_DEPTH : int'(sb.vec_len);
        bad = (lim < VEC_DEPTH) && (lim == 0 || $urandom_range(0, 6) == 0);
        repeat (16) begin
            c = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            if ((c >= lim) == bad) return c;
        end
        return bad ? VEC_DEPTH - 1 : 0;
    endfunction

    function automatic int load_index();
        int lim;
        lim = (sb.vec_len > VEC_DEPTH) ? VEC_DEPTH : int'(sb.vec_len);
        if (lim > 0 && $urandom_range(0, 3) != 0) return $urandom_range(0, lim - 1);
        return $urandom_range(0, VEC_DEPTH - 1);
    endfunction

    // A well-formed row: an empty-row request or nonzeros closed by row_end
    task automatic send_row();
        int nnz, roll;
        roll = $urandom_range(0, 19);
        if (roll < 2) nnz = 0;
        else if (roll == 2) nnz = $urandom_range(5, 12);
        else nnz = $urandom_range(1, 4);
        if (nnz == 0) begin
            send_req(OP_EMPTY, $urandom_range(0, VEC_DEPTH - 1), $urandom, $urandom_range(0, 1));
        end else begin
            for (int k = 0; k < nnz; k++)
                send_req(OP_NONZERO, pick_column(), pick_value(), k == nnz - 1);
        end
    endtask

    // Noise: unused opcode, stray vector write, or a nonzero that leaves its row open
    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_req(OP_NONE, $urandom_range(0, VEC_DEPTH - 1), $urandom,
                        $urandom_range(0, 1));
            1: send_req(OP_WRITE, $urandom_range(0, VEC_DEPTH - 1), pick_value(),
                        $urandom_range(0, 1));
            default: send_req(OP_NONZERO, pick_column(), pick_value(), 1'b0);
        endcase
    endtask

    // Load part of the vector, then stream rows; pause once halfway for the results
    task automatic run_phase(int budget);
        int  stop;
        bit  paused;
        stop   = sent_items + budget;
        paused = 1'b0;
        repeat ($urandom_range(6, 24))
            send_req(OP_WRITE, load_index(), pick_value(), $urandom_range(0, 1));
        while (sent_items < stop) begin
            if (!paused && sent_items >= stop - budget / 2) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 8) send_noise();
            else send_row();
        end
    endtask

    initial begin
        int phase_rows [7] = '{0, 65536, 3, -1, 131071, 5, 1};
        int phase_vlen [7] = '{1, 4096, 100, -1, 0, 8191, 4096};
        int nr, vl;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extremes of value and index under the reset settings
        send_req(OP_WRITE, 0, 32'h8000_0000, 1'b1);
        send_req(OP_WRITE, VEC_DEPTH - 1, 32'h7FFF_FFFF, 1'b0);
        send_req(OP_WRITE, 1, 32'h0001_0000, 1'b0);
        send_req(OP_WRITE, 2, 32'hFFFF_0000, 1'b0);
        // positive saturation, then negative saturation
        repeat (2) send_req(OP_NONZERO, 0, 32'h8000_0000, 1'b0);
        send_req(OP_NONZERO, 0, 32'h8000_0000, 1'b1);
        repeat (2) send_req(OP_NONZERO, 0, 32'h7FFF_FFFF, 1'b0);
        send_req(OP_NONZERO, 0, 32'h7FFF_FFFF, 1'b1);
        // just below the positive bound
        send_req(OP_NONZERO, VEC_DEPTH - 1, 32'h7FFF_FFFF, 1'b0);
        send_req(OP_NONZERO, 0, 32'h8000_0000, 1'b1);
        send_req(OP_EMPTY, 0, '0, 1'b1);
        send_req(OP_NONE, VEC_DEPTH - 1, 32'hFFFF_FFFF, 1'b1);
        // open row closed by an empty-row request carries its partial sum
        send_req(OP_NONZERO, 1, 32'h0002_8000, 1'b0);
        send_req(OP_NONZERO, 2, 32'h0001_0000, 1'b0);
        send_req(OP_EMPTY, 0, '0, 1'b0);
        // vector write in mid-row clears it; then read right behind the write
        send_req(OP_NONZERO, 1, 32'h0001_0000, 1'b0);
        send_req(OP_WRITE, 3, 32'h0003_0000, 1'b0);
        send_req(OP_NONZERO, 3, 32'h0001_0000, 1'b1);

        // Directed: bad columns with the shortest vector, two-row matrix
        cfg_write(REG_NUM_ROWS, 32'd2);
        cfg_write(REG_VEC_LENGTH, 32'd1);
        send_req(OP_NONZERO, VEC_DEPTH - 1, 32'd1, 1'b1);
        send_req(OP_NONZERO, 0, 32'hFFFF_FFFF, 1'b1);
        send_req(OP_NONZERO, 1, 32'h0001_0000, 1'b0);
        send_req(OP_NONZERO, 0, 32'h0001_0000, 1'b1);
        send_req(OP_EMPTY, 0, '0, 1'b0);

        // Random phases across register settings
        for (int p = 0; p < 7; p++) begin
            nr = (phase_rows[p] < 0) ? $urandom_range(1, 12) : phase_rows[p];
            vl = (phase_vlen[p] < 0) ? $urandom_range(1, 4096) : phase_vlen[p];
            cfg_write(REG_NUM_ROWS, nr);
            cfg_write(REG_VEC_LENGTH, vl);
            settings_done++;
            run_phase(120);
        end

        drain();
        $display("Sent %0d requests over %0d random register settings plus directed cases",
                 sent_items, settings_done);
        $display("Checked %0d row sums: %0d with a bad column, %0d ending the matrix, %0d saturated",
                 sb.rows_checked, sb.err_rows, sb.done_rows, sb.sat_rows);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
